// ===== design/mbsp_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI byte stream parser package
// Shared types and constants for the MIDI byte stream parser.
// ----------------------------------------------------------------------------
package mbsp_pkg;

   localparam logic [3:0] KIND_NOTE_OFF      = 4'd0;
   localparam logic [3:0] KIND_NOTE_ON       = 4'd1;
   localparam logic [3:0] KIND_POLY_PRESSURE = 4'd2;
   localparam logic [3:0] KIND_CONTROL       = 4'd3;
   localparam logic [3:0] KIND_PROGRAM       = 4'd4;
   localparam logic [3:0] KIND_CHAN_PRESSURE = 4'd5;
   localparam logic [3:0] KIND_BEND          = 4'd6;
   localparam logic [3:0] KIND_SYSTEM        = 4'd7;
   localparam logic [3:0] KIND_TEXT          = 4'd8;

   localparam logic [3:0] CLASS_PROGRAM       = 4'hC;
   localparam logic [3:0] CLASS_CHAN_PRESSURE = 4'hD;
   localparam logic [3:0] CLASS_BEND          = 4'hE;
   localparam logic [7:0] STATUS_META         = 8'hFF;

   typedef struct packed {
      logic [3:0]  event_kind;
      logic [3:0]  channel;
      logic [6:0]  param_one;
      logic [6:0]  param_two;
      logic [13:0] bend_value;
      logic [7:0]  text_byte;
      logic        text_last;
   } rsp_type;

endpackage

// ===== design/midi_byte_stream_parser_top.sv =====
// ----------------------------------------------------------------------------
// MIDI byte stream parser
// Parses received MIDI bytes with running status into events and comment text.
// ----------------------------------------------------------------------------
// An event is registered into the result register, or into the skid register while the result side stalls.
// Throughput: one byte per cycle while req_stall is low; parser state updates on each accepted byte.
// A two-entry output stage (result register and skid register) keeps input
// flowing while the result side stalls, until a second event is waiting.
// Reset is synchronous and clears parser state and the valid flags of both output entries.
module midi_byte_stream_parser_top
   import mbsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_event_kind,
   output logic [3:0]  rsp_channel,
   output logic [6:0]  rsp_param_one,
   output logic [6:0]  rsp_param_two,
   output logic [13:0] rsp_bend_value,
   output logic [7:0]  rsp_text_byte,
   output logic        rsp_text_last
);

   typedef enum logic [1:0] {
      PHASE_NONE,
      PHASE_LENGTH,
      PHASE_TEXT
   } phase_type;

   logic [7:0] running_status_ff, running_status_in;
   logic       status_valid_ff, status_valid_in;
   logic       data_index_ff, data_index_in;
   logic [6:0] first_data_ff, first_data_in;
   phase_type  phase_ff, phase_in;
   logic [7:0] text_remaining_ff, text_remaining_in;

   logic       out_valid_ff;
   rsp_type    out_ff;
   logic       skid_valid_ff;
   rsp_type    skid_ff;

   logic       accept;
   logic       pop;
   logic       has_result;
   rsp_type    result;
   logic [7:0] remaining_dec;
   logic [3:0] cls;
   logic [6:0] p1;
   logic [6:0] p2;
   logic       complete;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign pop       = out_valid_ff && !rsp_stall;

   always_comb begin
      running_status_in = running_status_ff;
      status_valid_in   = status_valid_ff;
      data_index_in     = data_index_ff;
      first_data_in     = first_data_ff;
      phase_in          = phase_ff;
      text_remaining_in = text_remaining_ff;
      has_result        = 1'b0;
      result            = '0;
      remaining_dec     = text_remaining_ff - 8'd1;
      cls               = running_status_ff[7:4];
      p1                = req_rx_byte[6:0];
      p2                = 7'd0;
      complete          = 1'b0;
      case (phase_ff)
         PHASE_LENGTH: begin
            if (req_rx_byte == 8'd0) begin
               phase_in          = PHASE_NONE;
               text_remaining_in = 8'd0;
               status_valid_in   = 1'b0;
               running_status_in = 8'd0;
               data_index_in     = 1'b0;
            end else begin
               text_remaining_in = req_rx_byte;
               phase_in          = PHASE_TEXT;
            end
         end
         PHASE_TEXT: begin
            has_result        = 1'b1;
            result.event_kind = KIND_TEXT;
            result.text_byte  = req_rx_byte;
            result.text_last  = (remaining_dec == 8'd0);
            text_remaining_in = remaining_dec;
            if (remaining_dec == 8'd0) begin
               phase_in          = PHASE_NONE;
               status_valid_in   = 1'b0;
               running_status_in = 8'd0;
               data_index_in     = 1'b0;
            end
         end
         default: begin
            phase_in = PHASE_NONE;
            if (req_rx_byte[7]) begin
               running_status_in = req_rx_byte;
               status_valid_in   = 1'b1;
               data_index_in     = 1'b0;
            end else if (status_valid_ff) begin
               if (!data_index_ff) begin
                  if (cls == CLASS_PROGRAM || cls == CLASS_CHAN_PRESSURE) begin
                     complete = 1'b1;
                  end else begin
                     first_data_in = req_rx_byte[6:0];
                     data_index_in = 1'b1;
                  end
               end else begin
                  p1            = first_data_ff;
                  p2            = req_rx_byte[6:0];
                  data_index_in = 1'b0;
                  complete      = 1'b1;
               end
               if (complete) begin
                  if (running_status_ff == STATUS_META && p1 == 7'd0 && p2 == 7'd0) begin
                     phase_in = PHASE_LENGTH;
                  end else begin
                     has_result        = 1'b1;
                     result.event_kind = {1'b0, cls[2:0]};
                     result.channel    = running_status_ff[3:0];
                     result.param_one  = p1;
                     result.param_two  = p2;
                     if (cls == CLASS_BEND) begin
                        result.bend_value = {p2, p1};
                     end
                  end
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_status_ff <= 8'd0;
         status_valid_ff   <= 1'b0;
         data_index_ff     <= 1'b0;
         first_data_ff     <= 7'd0;
         phase_ff          <= PHASE_NONE;
         text_remaining_ff <= 8'd0;
         out_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         if (accept) begin
            running_status_ff <= running_status_in;
            status_valid_ff   <= status_valid_in;
            data_index_ff     <= data_index_in;
            first_data_ff     <= first_data_in;
            phase_ff          <= phase_in;
            text_remaining_ff <= text_remaining_in;
         end
         if (pop || !out_valid_ff) begin
            if (skid_valid_ff) begin
               out_ff        <= skid_ff;
               out_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               out_ff       <= result;
               out_valid_ff <= accept && has_result;
            end
         end else if (accept && has_result) begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_event_kind = out_ff.event_kind;
   assign rsp_channel    = out_ff.channel;
   assign rsp_param_one  = out_ff.param_one;
   assign rsp_param_two  = out_ff.param_two;
   assign rsp_bend_value = out_ff.bend_value;
   assign rsp_text_byte  = out_ff.text_byte;
   assign rsp_text_last  = out_ff.text_last;

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// MIDI byte stream parser testbench
// Drives received bytes into the parser as words on the request channel and
// checks every event and comment text word against an in-bench prediction of
// the parser's running status and comment handling. Directed tests cover the
// edge values, each event class and the comment cases; a long random stream of
// mostly well-formed messages follows. Sender gaps, receiver stall patterns and
// one long receiver hold-off exercise the handshakes and the output stage.
// ----------------------------------------------------------------------------
module tb_top;
   import mbsp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 150;
   localparam int RANDOM_ITEMS = 580;

   typedef enum logic [1:0] {CMT_NONE, CMT_LENGTH, CMT_TEXT} cmt_state_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_event_kind;
   logic [3:0]  rsp_channel;
   logic [6:0]  rsp_param_one;
   logic [6:0]  rsp_param_two;
   logic [13:0] rsp_bend_value;
   logic [7:0]  rsp_text_byte;
   logic        rsp_text_last;

   midi_byte_stream_parser_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_event_kind (rsp_event_kind),
      .rsp_channel    (rsp_channel),
      .rsp_param_one  (rsp_param_one),
      .rsp_param_two  (rsp_param_two),
      .rsp_bend_value (rsp_bend_value),
      .rsp_text_byte  (rsp_text_byte),
      .rsp_text_last  (rsp_text_last)
   );

   // Parser state as predicted by the bench.
   logic [7:0]    cur_status = 8'h00;
   logic          have_status = 1'b0;
   logic          second_byte = 1'b0;
   logic [6:0]    held_data = 7'h00;
   cmt_state_type cmt_state = CMT_NONE;
   logic [7:0]    text_left = 8'h00;

   rsp_type     pending_events[$];
   rsp_type     head_event;
   int          mismatch_count = 0;
   int          useful_count = 0;
   int          cycle_count = 0;

   bit          gaps_on = 1'b1;
   int          burst_left = 4;
   logic [15:0] stall_pattern = 16'h0000;
   logic [3:0]  stall_phase = 4'd0;
   logic        hold_toggle = 1'b0;
   logic        hold_seen = 1'b0;
   int          hold_count = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   function automatic void close_comment();
      cmt_state   = CMT_NONE;
      text_left   = 8'h00;
      have_status = 1'b0;
      cur_status  = 8'h00;
      second_byte = 1'b0;
   endfunction

   function automatic bit predict_event(input logic [7:0] b, output rsp_type ev);
      logic [6:0] p1;
      logic [6:0] p2;
      ev = '0;
      p1 = 7'h00;
      p2 = 7'h00;
      if (cmt_state == CMT_LENGTH) begin
         if (b == 8'h00) begin
            close_comment();
         end else begin
            text_left = b;
            cmt_state = CMT_TEXT;
         end
         return 1'b0;
      end
      if (cmt_state == CMT_TEXT) begin
         text_left     = text_left - 8'd1;
         ev.event_kind = KIND_TEXT;
         ev.text_byte  = b;
         ev.text_last  = (text_left == 8'h00);
         if (text_left == 8'h00) close_comment();
         return 1'b1;
      end
      cmt_state = CMT_NONE;
      if (b[7]) begin
         cur_status  = b;
         have_status = 1'b1;
         second_byte = 1'b0;
         return 1'b0;
      end
      if (!have_status) return 1'b0;
      if (!second_byte) begin
         if (cur_status[7:4] == CLASS_PROGRAM || cur_status[7:4] == CLASS_CHAN_PRESSURE) begin
            p1 = b[6:0];
         end else begin
            held_data   = b[6:0];
            second_byte = 1'b1;
            return 1'b0;
         end
      end else begin
         p1          = held_data;
         p2          = b[6:0];
         second_byte = 1'b0;
      end
      if (cur_status == STATUS_META && p1 == 7'h00 && p2 == 7'h00) begin
         cmt_state = CMT_LENGTH;
         return 1'b0;
      end
      ev.event_kind = {1'b0, cur_status[6:4]};
      ev.channel    = cur_status[3:0];
      ev.param_one  = p1;
      ev.param_two  = p2;
      if (cur_status[7:4] == CLASS_BEND) ev.bend_value = {p2, p1};
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_field(input string what, input int got, input int want);
      if (got != want) report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            report_mismatch("unexpected event, kind", int'(rsp_event_kind), -1);
         end else begin
            head_event = pending_events.pop_front();
            check_field("event_kind", int'(rsp_event_kind), int'(head_event.event_kind));
            check_field("channel", int'(rsp_channel), int'(head_event.channel));
            check_field("param_one", int'(rsp_param_one), int'(head_event.param_one));
            check_field("param_two", int'(rsp_param_two), int'(head_event.param_two));
            check_field("bend_value", int'(rsp_bend_value), int'(head_event.bend_value));
            check_field("text_byte", int'(rsp_text_byte), int'(head_event.text_byte));
            check_field("text_last", int'(rsp_text_last), int'(head_event.text_last));
         end
      end
   end

   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen  <= hold_toggle;
         hold_count <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else if (hold_count != 0) begin
         hold_count <= hold_count - 1;
         rsp_stall  <= 1'b1;
      end else begin
         stall_phase <= stall_phase + 4'd1;
         rsp_stall   <= stall_pattern[stall_phase];
      end
   end

   task automatic send_byte(input logic [7:0] b);
      rsp_type ev;
      int      gap;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (b[7] || have_status || cmt_state != CMT_NONE) useful_count++;
      if (predict_event(b, ev)) pending_events.push_back(ev);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 12);
         if (gaps_on) begin
            gap = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   function automatic logic [6:0] random_data();
      case ($urandom_range(0, 7))
         0: return 7'h00;
         1: return 7'h7F;
         default: return 7'($urandom_range(0, 127));
      endcase
   endfunction

   function automatic logic [7:0] random_status();
      int k;
      k = $urandom_range(0, 9);
      if (k < 7) return {1'b1, 3'(k), 4'($urandom_range(0, 15))};
      if (k < 9) return {4'hF, 4'($urandom_range(0, 15))};
      return STATUS_META;
   endfunction

   function automatic int data_count(input logic [7:0] status);
      if (status[7:4] == CLASS_PROGRAM || status[7:4] == CLASS_CHAN_PRESSURE) return 1;
      return 2;
   endfunction

   task automatic send_random_message();
      int         pick;
      int         n;
      int         len;
      logic [7:0] st;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         if (have_status && cmt_state == CMT_NONE && $urandom_range(0, 9) < 4) begin
            n = data_count(cur_status);
         end else begin
            st = random_status();
            send_byte(st);
            n = data_count(st);
         end
         repeat (n) send_byte({1'b0, random_data()});
      end else if (pick < 80) begin
         send_byte(STATUS_META);
         send_byte(8'h00);
         send_byte(8'h00);
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
         send_byte(8'(len));
         repeat (len) send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
         send_byte(8'($urandom_range(0, 255)));
      end else begin
         send_byte({1'b1, 3'($urandom_range(0, 6)), 4'($urandom_range(0, 15))});
         send_byte({1'b0, random_data()});
      end
   endtask

   task automatic test_before_status();
      send_byte(8'h7F);
      send_byte(8'h00);
   endtask

   task automatic test_channel_events();
      send_byte(8'h80); send_byte(8'h00); send_byte(8'h7F);
      send_byte(8'h9F); send_byte(8'h7F); send_byte(8'h00);
      send_byte(8'hC3); send_byte(8'h7F); send_byte(8'h55);
      send_byte(8'hDA); send_byte(8'h00);
      send_byte(8'hE7); send_byte(8'h7F); send_byte(8'h7F);
   endtask

   task automatic test_status_restart();
      send_byte(8'hA1); send_byte(8'h10);
      send_byte(8'hB2); send_byte(8'h05); send_byte(8'h06);
   endtask

   task automatic test_system_events();
      send_byte(STATUS_META); send_byte(8'h01); send_byte(8'h02);
   endtask

   task automatic test_comment();
      send_byte(STATUS_META); send_byte(8'h00); send_byte(8'h00);
      send_byte(8'h03); send_byte(8'h80); send_byte(8'hFF); send_byte(8'h41);
      send_byte(8'h10);
   endtask

   task automatic test_zero_length_comment();
      send_byte(STATUS_META); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
      send_byte(8'h20);
   endtask

   task automatic test_backpressure();
      gaps_on = 1'b0;
      stall_pattern <= 16'h0000;
      hold_toggle <= ~hold_toggle;
      send_byte(8'hC5);
      for (int i = 0; i < 24; i++) send_byte(8'(i * 5));
      gaps_on = 1'b1;
   endtask

   task automatic test_random_stream();
      int target;
      target = useful_count;
      for (int phase = 0; phase < 4; phase++) begin
         gaps_on = phase[0];
         stall_pattern <= phase[1] ? (16'($urandom_range(0, 65535)) & 16'hFFFE) : 16'h0000;
         target += RANDOM_ITEMS / 4;
         while (useful_count < target) send_random_message();
      end
   endtask

   initial begin
      stall_pattern <= 16'h3C5A;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_before_status();
      test_channel_events();
      test_status_restart();
      test_system_events();
      test_comment();
      test_zero_length_comment();
      test_backpressure();
      test_random_stream();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
